### rtl/tcc_pkg.sv
// Shared types and constants of the text console cursor engine.
package tcc_pkg;

   localparam int CMD_W     = 2;
   localparam int CHAR_W    = 8;
   localparam int INDEX_W   = 11;
   localparam int ATTR_W    = 8;
   localparam int CELL_W    = 16;
   localparam int ROW_OUT_W = 5;
   localparam int COL_OUT_W = 7;
   localparam int POS_OUT_W = 11;

   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

   typedef enum logic [5:0] {
      ST_INIT   = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_EXEC   = 6'b000100,
      ST_SCROLL = 6'b001000,
      ST_FILL   = 6'b010000,
      ST_DONE   = 6'b100000
   } tcc_state_type;

   typedef struct packed {
      logic accept;
      logic exec_put;
      logic start_clear;
      logic read_issue;
      logic fill_step;
      logic scroll_step;
      logic sweep_rst;
      logic load_rsp;
   } tcc_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             put_scroll;
      logic             sweep_end;
   } tcc_status_type;

endpackage

### rtl/tcc_req_if.sv
// Request channel: one word per console command.
interface tcc_req_if;
   import tcc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     command;
   logic [CHAR_W-1:0]    char_code;
   logic [INDEX_W-1:0]   cell_index;

   modport source (output valid, command, char_code, cell_index, input ready);
   modport sink   (input valid, command, char_code, cell_index, output ready);
endinterface

### rtl/tcc_rsp_if.sv
// Response channel: one word per completed console command.
interface tcc_rsp_if;
   import tcc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [ROW_OUT_W-1:0]   cursor_row;
   logic [COL_OUT_W-1:0]   cursor_column;
   logic [POS_OUT_W-1:0]   cursor_position;
   logic [CELL_W-1:0]      cell_value;
   logic                   scrolled;

   modport source (output valid, cursor_row, cursor_column, cursor_position, cell_value,
                   scrolled, input ready);
   modport sink   (input valid, cursor_row, cursor_column, cursor_position, cell_value,
                   scrolled, output ready);
endinterface

### rtl/tcc_datapath.sv
// Datapath: cursor registers, screen store, sweep counter and response register.
module tcc_datapath #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [tcc_pkg::ATTR_W-1:0]        csr_wr_data,
   input  logic [tcc_pkg::CMD_W-1:0]         req_command,
   input  logic [tcc_pkg::CHAR_W-1:0]        req_char_code,
   input  logic [tcc_pkg::INDEX_W-1:0]       req_cell_index,
   input  tcc_pkg::tcc_cmd_type              ctl,
   output tcc_pkg::tcc_status_type           sts,
   output logic [tcc_pkg::ROW_OUT_W-1:0]     rsp_cursor_row,
   output logic [tcc_pkg::COL_OUT_W-1:0]     rsp_cursor_column,
   output logic [tcc_pkg::POS_OUT_W-1:0]     rsp_cursor_position,
   output logic [tcc_pkg::CELL_W-1:0]        rsp_cell_value,
   output logic                              rsp_scrolled
);
   import tcc_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int SW    = $clog2(CELLS + 1);
   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLUMNS);

   localparam logic [AW-1:0] LAST_BASE = AW'((ROWS - 1) * COLUMNS);
   localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
   localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
   localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
   localparam logic [SW-1:0] SRC_LIMIT = SW'(CELLS - COLUMNS);
   localparam logic [SW-1:0] SWEEP_END = SW'(CELLS);
   localparam logic [CW:0]   TAB_STEP  = (CW + 1)'(4);
   localparam logic [CW:0]   COL_LIMIT = (CW + 1)'(COLUMNS);

   logic [CELL_W-1:0] mem [CELLS];

   logic [ATTR_W-1:0]  attr_ff, fill_attr_ff;
   logic [CMD_W-1:0]   cmd_ff;
   logic [CHAR_W-1:0]  char_ff;
   logic [INDEX_W-1:0] idx_ff;
   logic [RW-1:0]      row_ff, row_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic               scrolled_ff;
   logic [SW-1:0]      sweep_ff;
   logic [AW-1:0]      lag_addr_ff;
   logic               lag_src_ff, lag_vld_ff;
   logic [CELL_W-1:0]  rd_data_ff;

   logic [ROW_OUT_W-1:0] out_row_ff;
   logic [COL_OUT_W-1:0] out_col_ff;
   logic [POS_OUT_W-1:0] out_pos_ff;
   logic [CELL_W-1:0]    out_value_ff;
   logic                 out_scrolled_ff;

   logic [AW-1:0]     line_start;
   logic [CW:0]       tab_sum, tab_col;
   logic              new_line, at_bottom, put_write, put_scroll;
   logic              src_ok, in_range;
   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_wa, mem_ra;
   logic [CELL_W-1:0] mem_wd;
   logic [SW-1:0]     src_addr;

   // cursor update for a put
   always_comb begin
      row_in     = row_ff;
      col_in     = col_ff;
      pos_in     = pos_ff;
      new_line   = 1'b0;
      put_write  = 1'b0;
      line_start = pos_ff - AW'(col_ff);
      at_bottom  = (row_ff == LAST_ROW);
      tab_sum    = {1'b0, col_ff} + TAB_STEP;
      tab_col    = {tab_sum[CW:2], 2'b00};
      case (char_ff)
         CHAR_NEWLINE: begin
            new_line = 1'b1;
         end
         CHAR_RETURN: begin
            col_in = '0;
            pos_in = line_start;
         end
         CHAR_BACKSPACE: begin
            if (col_ff != '0) begin
               col_in = col_ff - 1'b1;
               pos_in = pos_ff - 1'b1;
            end else if (row_ff != '0) begin
               row_in = row_ff - 1'b1;
               col_in = LAST_COL;
               pos_in = pos_ff - 1'b1;
            end
         end
         CHAR_TAB: begin
            if (tab_col >= COL_LIMIT) begin
               new_line = 1'b1;
            end else begin
               col_in = CW'(tab_col);
               pos_in = pos_ff + AW'(tab_col - {1'b0, col_ff});
            end
         end
         default: begin
            put_write = 1'b1;
            if (col_ff == LAST_COL) begin
               new_line = 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
               pos_in = pos_ff + 1'b1;
            end
         end
      endcase
      if (new_line) begin
         col_in = '0;
         if (at_bottom) begin
            pos_in = LAST_BASE;
         end else begin
            row_in = row_ff + 1'b1;
            pos_in = line_start + ROW_STEP;
         end
      end
      put_scroll = new_line && at_bottom;
   end

   assign src_ok   = (sweep_ff < SRC_LIMIT);
   assign src_addr = sweep_ff + SW'(COLUMNS);
   assign in_range = (32'(idx_ff) < CELLS);

   always_comb begin
      sts.command    = cmd_ff;
      sts.put_scroll = put_scroll;
      sts.sweep_end  = (sweep_ff == SWEEP_END);
   end

   // store port selection
   always_comb begin
      mem_we = 1'b0;
      mem_wa = '0;
      mem_wd = '0;
      if (ctl.exec_put && put_write) begin
         mem_we = 1'b1;
         mem_wa = pos_ff;
         mem_wd = {attr_ff, char_ff};
      end else if (ctl.fill_step) begin
         mem_we = 1'b1;
         mem_wa = AW'(sweep_ff);
         mem_wd = {fill_attr_ff, CHAR_SPACE};
      end else if (lag_vld_ff) begin
         mem_we = 1'b1;
         mem_wa = lag_addr_ff;
         mem_wd = lag_src_ff ? rd_data_ff : {attr_ff, CHAR_SPACE};
      end
      mem_re = 1'b0;
      mem_ra = '0;
      if (ctl.read_issue) begin
         mem_re = 1'b1;
         mem_ra = AW'(idx_ff);
      end else if (ctl.scroll_step && src_ok) begin
         mem_re = 1'b1;
         mem_ra = AW'(src_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= ATTR_RESET;
         fill_attr_ff <= ATTR_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         pos_ff       <= '0;
         sweep_ff     <= '0;
         lag_vld_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            attr_ff <= csr_wr_data;
         end
         if (ctl.start_clear) begin
            fill_attr_ff <= attr_ff;
            row_ff       <= '0;
            col_ff       <= '0;
            pos_ff       <= '0;
         end else if (ctl.exec_put) begin
            row_ff <= row_in;
            col_ff <= col_in;
            pos_ff <= pos_in;
         end
         if (ctl.sweep_rst) begin
            sweep_ff <= '0;
         end else if (ctl.fill_step || ctl.scroll_step) begin
            sweep_ff <= sweep_ff + 1'b1;
         end
         lag_vld_ff <= ctl.scroll_step;
      end
   end

   always_ff @(posedge clock) begin
      lag_addr_ff <= AW'(sweep_ff);
      lag_src_ff  <= src_ok;
      if (ctl.accept) begin
         cmd_ff      <= req_command;
         char_ff     <= req_char_code;
         idx_ff      <= req_cell_index;
         scrolled_ff <= 1'b0;
      end else if (ctl.exec_put) begin
         scrolled_ff <= put_scroll;
      end
      if (ctl.load_rsp) begin
         out_row_ff      <= ROW_OUT_W'(row_ff);
         out_col_ff      <= COL_OUT_W'(col_ff);
         out_pos_ff      <= POS_OUT_W'(pos_ff);
         out_value_ff    <= (cmd_ff == CMD_READ && in_range) ? rd_data_ff : '0;
         out_scrolled_ff <= scrolled_ff;
      end
   end

   assign rsp_cursor_row      = out_row_ff;
   assign rsp_cursor_column   = out_col_ff;
   assign rsp_cursor_position = out_pos_ff;
   assign rsp_cell_value      = out_value_ff;
   assign rsp_scrolled        = out_scrolled_ff;

endmodule

### rtl/tcc_ctrl.sv
// Controller: sequences accept, execute, store sweeps and response handoff.
module tcc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  tcc_pkg::tcc_status_type sts,
   output tcc_pkg::tcc_cmd_type    ctl
);
   import tcc_pkg::*;

   tcc_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         ST_INIT: begin
            if (sts.sweep_end) begin
               ctl.sweep_rst = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               ctl.fill_step = 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               ctl.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (sts.command)
               CMD_PUT: begin
                  ctl.exec_put = 1'b1;
                  state_in     = sts.put_scroll ? ST_SCROLL : ST_DONE;
               end
               CMD_CLEAR: begin
                  ctl.start_clear = 1'b1;
                  state_in        = ST_FILL;
               end
               CMD_READ: begin
                  ctl.read_issue = 1'b1;
                  state_in       = ST_DONE;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_SCROLL: begin
            if (sts.sweep_end) begin
               ctl.sweep_rst = 1'b1;
               state_in      = ST_DONE;
            end else begin
               ctl.scroll_step = 1'b1;
            end
         end
         ST_FILL: begin
            if (sts.sweep_end) begin
               ctl.sweep_rst = 1'b1;
               state_in      = ST_DONE;
            end else begin
               ctl.fill_step = 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/text_console_cursor_engine_top.sv
// Top level of the text console cursor engine.
// Text console engine over a ROWS x COLUMNS store of 16-bit cells (attribute in the high
// byte, character in the low byte) with a cursor. One command word is in flight at a time:
// a put, a read or an unused command is taken, executed and then written to the response
// register, which is loaded once it is free or its word is being taken; a read uses the
// registered read port of the screen store. A put that runs off the bottom row, and a
// clear, add one sweep over every cell of the store, one cell copied or blanked per cycle
// through its single write port. After reset a blanking sweep runs before the first word
// is taken; attribute writes are taken at any time. A finished response waits in its
// register while the next command word is taken.
module text_console_cursor_engine_top #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [tcc_pkg::ATTR_W-1:0]  csr_wr_data,
   tcc_req_if.sink                     req_chan,
   tcc_rsp_if.source                   rsp_chan
);
   import tcc_pkg::*;

   tcc_cmd_type    ctl;
   tcc_status_type sts;

   tcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   tcc_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_command         (req_chan.command),
      .req_char_code       (req_chan.char_code),
      .req_cell_index      (req_chan.cell_index),
      .ctl                 (ctl),
      .sts                 (sts),
      .rsp_cursor_row      (rsp_chan.cursor_row),
      .rsp_cursor_column   (rsp_chan.cursor_column),
      .rsp_cursor_position (rsp_chan.cursor_position),
      .rsp_cell_value      (rsp_chan.cell_value),
      .rsp_scrolled        (rsp_chan.scrolled)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("command word taken while another is in flight");

   a_init_blocks: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_chan.ready)
      else $error("command word taken before the blanking sweep");

   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.scrolled) |->
         (rsp_chan.cursor_column == '0 && rsp_chan.cursor_row == ROW_OUT_W'(ROWS - 1)))
      else $error("scroll left the cursor off the start of the last row");

   a_ctl_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.exec_put, ctl.fill_step, ctl.scroll_step, ctl.read_issue}))
      else $error("conflicting store operations in one cycle");

endmodule

### test/tcc_console_checker.sv
// Scoreboard that mirrors the console screen and cursor and checks every response word.
module tcc_console_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [tcc_pkg::ATTR_W-1:0]  csr_wr_data,
   tcc_req_if                          req_chan,
   tcc_rsp_if                          rsp_chan,
   output int                          mismatch_count,
   output int                          words_pending
);
   import tcc_pkg::*;

   localparam int CELL_COUNT   = ROWS * COLUMNS;
   localparam int TAB_STOP     = 4;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [ROW_OUT_W-1:0] row;
      logic [COL_OUT_W-1:0] column;
      logic [POS_OUT_W-1:0] position;
      logic [CELL_W-1:0]    cell_data;
      logic                 scrolled;
   } cursor_report_type;

   logic [CELL_W-1:0] screen_mirror [CELL_COUNT];
   logic [ATTR_W-1:0] attr_mirror;
   int unsigned       row_mirror;
   int unsigned       column_mirror;
   cursor_report_type reports_due [$];
   int                fail_total = 0;

   function automatic void blank_screen(logic [ATTR_W-1:0] attr);
      for (int i = 0; i < CELL_COUNT; i++) screen_mirror[i] = {attr, CHAR_SPACE};
   endfunction

   function automatic logic advance_line();
      column_mirror = 0;
      row_mirror++;
      if (row_mirror >= ROWS) begin
         for (int i = 0; i + COLUMNS < CELL_COUNT; i++)
            screen_mirror[i] = screen_mirror[i + COLUMNS];
         for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
            screen_mirror[i] = {attr_mirror, CHAR_SPACE};
         row_mirror = ROWS - 1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic put_char(logic [CHAR_W-1:0] ch);
      int unsigned cell_at;
      logic        rolled;
      rolled = 1'b0;
      case (ch)
         CHAR_NEWLINE: rolled = advance_line();
         CHAR_RETURN: column_mirror = 0;
         CHAR_BACKSPACE: begin
            if (column_mirror > 0) begin
               column_mirror--;
            end else if (row_mirror > 0) begin
               row_mirror--;
               column_mirror = COLUMNS - 1;
            end
         end
         CHAR_TAB: begin
            column_mirror = (column_mirror + TAB_STOP) & ~(TAB_STOP - 1);
            if (column_mirror >= COLUMNS) rolled = advance_line();
         end
         default: begin
            cell_at = row_mirror * COLUMNS + column_mirror;
            if (cell_at < CELL_COUNT) screen_mirror[cell_at] = {attr_mirror, ch};
            column_mirror++;
            if (column_mirror >= COLUMNS) rolled = advance_line();
         end
      endcase
      return rolled;
   endfunction

   function automatic cursor_report_type console_step(logic [CMD_W-1:0] command,
         logic [CHAR_W-1:0] ch, logic [INDEX_W-1:0] index);
      cursor_report_type report;
      report = '0;
      case (command)
         CMD_PUT: report.scrolled = put_char(ch);
         CMD_CLEAR: begin
            blank_screen(attr_mirror);
            row_mirror    = 0;
            column_mirror = 0;
         end
         CMD_READ: begin
            if (index < CELL_COUNT) report.cell_data = screen_mirror[index];
         end
         default: ;
      endcase
      report.row      = ROW_OUT_W'(row_mirror);
      report.column   = COL_OUT_W'(column_mirror);
      report.position = POS_OUT_W'(row_mirror * COLUMNS + column_mirror);
      return report;
   endfunction

   always @(posedge clock) begin
      cursor_report_type seen;
      cursor_report_type due;
      if (reset) begin
         blank_screen(ATTR_RESET);
         attr_mirror   = ATTR_RESET;
         row_mirror    = 0;
         column_mirror = 0;
         reports_due.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen = {rsp_chan.cursor_row, rsp_chan.cursor_column, rsp_chan.cursor_position,
                    rsp_chan.cell_value, rsp_chan.scrolled};
            if (reports_due.size() == 0) begin
               fail_total++;
               if (fail_total <= REPORT_LIMIT)
                  $display("%0t: response word with none expected: row %0d col %0d pos %0d",
                           $time, seen.row, seen.column, seen.position);
            end else begin
               due = reports_due.pop_front();
               if (seen != due) begin
                  fail_total++;
                  if (fail_total <= REPORT_LIMIT) begin
                     $display("%0t: expected row %0d col %0d pos %0d cell %h scrolled %0b",
                              $time, due.row, due.column, due.position, due.cell_data,
                              due.scrolled);
                     $display("%0t:   actual row %0d col %0d pos %0d cell %h scrolled %0b",
                              $time, seen.row, seen.column, seen.position, seen.cell_data,
                              seen.scrolled);
                  end
               end
            end
         end
         if (csr_wr_en) attr_mirror = csr_wr_data;
         if (req_chan.valid && req_chan.ready)
            reports_due.push_back(console_step(req_chan.command, req_chan.char_code,
                                               req_chan.cell_index));
      end
      mismatch_count <= fail_total;
      words_pending  <= reports_due.size();
   end

endmodule

### test/tb_top.sv
// Testbench top: clock, reset, stimulus and verdict for the text console engine.
module tb_top;
   import tcc_pkg::*;

   localparam int COLUMNS       = 80;
   localparam int ROWS          = 25;
   localparam int CELL_COUNT    = ROWS * COLUMNS;
   localparam int RESET_CYCLES  = 11;
   localparam int IDLE_LIMIT    = 20000;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 400;
   localparam int PHASES        = 6;
   localparam int PHASE_WORDS   = 150;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [ATTR_W-1:0] csr_wr_data;
   int                mismatch_count;
   int                words_pending;
   int                idle_cycles = 0;
   bit                hold_wanted = 1'b0;
   bit                hold_done = 1'b0;

   tcc_req_if req_if();
   tcc_rsp_if rsp_if();

   text_console_cursor_engine_top #(.COLUMNS(COLUMNS), .ROWS(ROWS)) DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if)
   );

   tcc_console_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) console_mirror (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_chan       (req_if),
      .rsp_chan       (rsp_if),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[text_console_cursor_engine_top] ERROR");
         $finish;
      end
   end

   // response side: stall pattern of its own, plus one long hold-off on request
   initial begin
      int mode;
      int span;
      int tick;
      int hold_left;
      rsp_if.ready <= 1'b0;
      tick = 0;
      hold_left = 0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 200);
         repeat (span) begin
            @(posedge clock);
            tick++;
            if (hold_wanted && !hold_done) begin
               hold_done = 1'b1;
               hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp_if.ready <= 1'b0;
            end else begin
               case (mode)
                  0: rsp_if.ready <= 1'b1;
                  1: rsp_if.ready <= 1'($urandom_range(0, 1));
                  2: rsp_if.ready <= (tick % 4) == 0;
                  default: rsp_if.ready <= $urandom_range(0, 7) != 0;
               endcase
            end
         end
      end
   end

   task automatic send_word(logic [CMD_W-1:0] command, logic [CHAR_W-1:0] ch,
         logic [INDEX_W-1:0] index);
      req_if.valid      <= 1'b1;
      req_if.command    <= command;
      req_if.char_code  <= ch;
      req_if.cell_index <= index;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (words_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_attribute(logic [ATTR_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_random_word(int newline_pct);
      int                 pick;
      logic [CHAR_W-1:0]  ch;
      logic [INDEX_W-1:0] index;
      pick  = $urandom_range(0, 999);
      ch    = CHAR_W'($urandom());
      index = INDEX_W'($urandom());
      if (pick < 3) begin
         send_word(CMD_CLEAR, ch, index);
      end else if (pick < 15) begin
         send_word(CMD_UNUSED, ch, index);
      end else if (pick < 165) begin
         if ($urandom_range(0, 9) != 0) index = INDEX_W'($urandom_range(0, CELL_COUNT - 1));
         send_word(CMD_READ, ch, index);
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < newline_pct) ch = CHAR_NEWLINE;
         else if (pick < newline_pct + 6) ch = CHAR_TAB;
         else if (pick < newline_pct + 11) ch = CHAR_BACKSPACE;
         else if (pick < newline_pct + 14) ch = CHAR_RETURN;
         send_word(CMD_PUT, ch, index);
      end
   endtask

   initial begin
      int                burst_left;
      int                gap;
      int                newline_pct [PHASES];
      logic [ATTR_W-1:0] phase_attr [PHASES];
      newline_pct = '{2, 18, 6, 30, 10, 3};
      phase_attr  = '{8'h00, 8'hFF, ATTR_W'($urandom()), ATTR_W'($urandom()),
                      ATTR_W'($urandom()), ATTR_RESET};
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      req_if.valid      <= 1'b0;
      req_if.command    <= CMD_PUT;
      req_if.char_code  <= '0;
      req_if.cell_index <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset contents, edge addresses, cursor moves at the top-left corner
      send_word(CMD_READ, 8'h00, '0);
      send_word(CMD_READ, 8'hFF, INDEX_W'(CELL_COUNT - 1));
      send_word(CMD_READ, 8'h00, INDEX_W'(CELL_COUNT));
      send_word(CMD_READ, 8'h00, '1);
      send_word(CMD_PUT, 8'h41, '0);
      send_word(CMD_PUT, 8'hFF, '1);
      send_word(CMD_PUT, 8'h00, '0);
      send_word(CMD_READ, 8'h00, '0);
      send_word(CMD_READ, 8'h00, INDEX_W'(2));
      send_word(CMD_PUT, CHAR_TAB, '0);
      send_word(CMD_PUT, CHAR_TAB, '0);
      send_word(CMD_PUT, CHAR_BACKSPACE, '0);
      send_word(CMD_PUT, CHAR_RETURN, '0);
      send_word(CMD_PUT, CHAR_BACKSPACE, '0);
      send_word(CMD_PUT, CHAR_NEWLINE, '0);
      send_word(CMD_PUT, CHAR_BACKSPACE, '0);
      send_word(CMD_PUT, 8'h7E, '0);
      send_word(CMD_READ, 8'h00, INDEX_W'(COLUMNS - 1));
      send_word(CMD_UNUSED, 8'hFF, '1);
      wait_drained();

      write_attribute(8'hC3);
      send_word(CMD_CLEAR, 8'h00, '0);
      send_word(CMD_READ, 8'h00, '0);
      send_word(CMD_PUT, 8'h5A, '0);
      send_word(CMD_READ, 8'h00, '0);
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         write_attribute(phase_attr[phase]);
         if (phase == 0) hold_wanted = 1'b1;
         burst_left = 0;
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (burst_left == 0) begin
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 12);
               gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               if (gap > 0 && n > 0) begin
                  req_if.valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
            send_random_word(newline_pct[phase]);
            burst_left--;
         end
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && words_pending == 0)
         $display("[text_console_cursor_engine_top] OK");
      else
         $display("[text_console_cursor_engine_top] ERROR");
      $finish;
   end

endmodule
